@@ hdl/like_wildcard_matcher_core_macros.svh @@
// Assertion macros for the LIKE wildcard matcher checker.
// Each macro expands to one labeled concurrent assertion, clocked and reset-qualified.
`ifndef LIKE_WILDCARD_MATCHER_CORE_MACROS_SVH
`define LIKE_WILDCARD_MATCHER_CORE_MACROS_SVH

// Antecedent holds -> consequent in the same cycle.
`define LWM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds -> consequent in the next cycle.
`define LWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/lwm_pkg.sv @@
// Shared types and constants for the LIKE wildcard matcher.
// No dependencies; used by lwm_cell and like_wildcard_matcher_core.
`timescale 1ns / 1ps

package lwm_pkg;

    localparam logic [7:0] SYM_PERCENT    = 8'h25;
    localparam logic [7:0] SYM_UNDERSCORE = 8'h5F;
    localparam logic [7:0] SYM_NUL        = 8'h00;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_TEXT   = 2'd2,
        FUNC_END    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        TRUTH_FALSE   = 2'd0,
        TRUTH_TRUE    = 2'd1,
        TRUTH_UNKNOWN = 2'd2
    } t_truth;

    // What every cell does this cycle.
    typedef enum logic [1:0] {
        CELL_HOLD    = 2'd0,
        CELL_ADVANCE = 2'd1,
        CELL_RESTART = 2'd2
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode mode;
        logic       append;   // store sym at the cell whose index equals the current length
        logic [7:0] sym;      // pattern byte on append, text byte on advance
    } t_cell_ctrl;

endpackage

@@ hdl/lwm_cell.sv @@
// One pattern position of the LIKE matcher: stored byte plus live bit.
// Depends on lwm_pkg; chained by like_wildcard_matcher_core.
`timescale 1ns / 1ps

module lwm_cell #(
    parameter int LEN_W = 6,
    parameter int IDX   = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lwm_pkg::t_cell_ctrl i_ctrl,
    input  logic [LEN_W-1:0]  i_len,
    input  logic [LEN_W-1:0]  i_len_next,
    input  logic              i_adv,
    input  logic              i_carry,
    output logic              o_adv,
    output logic              o_carry,
    output logic              o_live
);

    localparam logic [LEN_W-1:0] MY_IDX = LEN_W'(IDX);

    logic [7:0] r_sym;
    logic       r_live;
    logic       n_live;
    logic       wr;
    logic [7:0] sym_next;
    logic       used_cur;
    logic       used_next;
    logic       pct_cur;
    logic       pct_next;
    logic       match;
    logic       pre;
    logic       post;

    assign wr        = i_ctrl.append && (i_len == MY_IDX);
    assign sym_next  = wr ? i_ctrl.sym : r_sym;
    assign used_cur  = MY_IDX < i_len;
    assign used_next = MY_IDX < i_len_next;
    assign pct_cur   = used_cur && (r_sym == lwm_pkg::SYM_PERCENT);
    assign pct_next  = used_next && (sym_next == lwm_pkg::SYM_PERCENT);
    assign match     = used_cur && !pct_cur &&
                       ((r_sym == lwm_pkg::SYM_UNDERSCORE) || (r_sym == i_ctrl.sym));

    // Consume one text byte: hand the token to the right neighbor.
    assign o_adv = (i_ctrl.mode == lwm_pkg::CELL_ADVANCE) && r_live && match;

    always_comb begin
        unique case (i_ctrl.mode)
            lwm_pkg::CELL_HOLD:    pre = r_live;
            lwm_pkg::CELL_ADVANCE: pre = (r_live && pct_cur) || i_adv;
            lwm_pkg::CELL_RESTART: pre = i_adv;
            default:               pre = r_live;
        endcase
    end

    // Percent closure ripples rightward through runs of '%'.
    assign post    = pre || i_carry;
    assign o_carry = post && pct_next;
    assign n_live  = (i_ctrl.mode == lwm_pkg::CELL_HOLD) ? r_live : post;
    assign o_live  = r_live;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= (IDX == 0);
        end else begin
            r_live <= n_live;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_sym <= i_ctrl.sym;
        end
    end

endmodule

@@ hdl/like_wildcard_matcher_core.sv @@
// SQL LIKE wildcard matcher: top level with the cell chain and result stage.
// Depends on lwm_pkg and lwm_cell.
`timescale 1ns / 1ps

// Usage
//   Request channel (i_valid / o_stall, fields i_func, i_symbol):
//     FUNC_CLEAR empties the pattern, FUNC_APPEND adds one pattern byte,
//     FUNC_TEXT feeds one text byte, FUNC_END closes the text and asks for a result.
//     A zero symbol on append or text is dropped without effect.
//   Result channel (o_valid / i_stall, fields o_truth, o_pattern_overflow):
//     one result per FUNC_END: false, true, or unknown when the text or the
//     pattern was empty. o_pattern_overflow flags a pattern cut at MAX_PATTERN bytes.
//   Throughput: one request per cycle of any kind while o_stall is low. Each
//     pattern position is a cell; all cells update in parallel from the
//     previous live set, so the whole chain consumes a text byte in one update.
//   Result: a FUNC_END result is registered in the output register, or in the skid.
//   Stall: a two-entry result stage (output register plus skid) absorbs one
//     extra result; o_stall rises only while both entries are full.
//   Reset (synchronous, active low): empty pattern, no overflow, no text seen,
//     only position zero live, result stage empty. No clearing pass is needed.
module like_wildcard_matcher_core #(
    parameter int MAX_PATTERN = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_func,
    input  logic [7:0] i_symbol,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_truth,
    output logic       o_pattern_overflow
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

    lwm_pkg::t_cell_ctrl ctrl;
    lwm_pkg::t_func      func;
    lwm_pkg::t_truth     result_truth;

    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   n_len;
    logic               r_ovf;
    logic               n_ovf;
    logic               r_text_seen;
    logic               n_text_seen;
    logic               r_live_last;
    logic               n_live_last;
    logic               accept;
    logic               take_end;
    logic               out_take;
    logic [MAX_PATTERN:0] adv;
    logic [MAX_PATTERN:0] carry;
    logic [MAX_PATTERN:0] live_vec;

    logic               r_out_valid;
    lwm_pkg::t_truth    r_out_truth;
    logic               r_out_ovf;
    logic               r_skid_valid;
    lwm_pkg::t_truth    r_skid_truth;
    logic               r_skid_ovf;

    assign accept   = i_valid && !o_stall;
    assign func     = lwm_pkg::t_func'(i_func);
    assign out_take = r_out_valid && !i_stall;

    // Decode the request into a command for the whole chain.
    always_comb begin
        ctrl.mode   = lwm_pkg::CELL_HOLD;
        ctrl.append = 1'b0;
        ctrl.sym    = i_symbol;
        n_len       = r_len;
        n_ovf       = r_ovf;
        n_text_seen = r_text_seen;
        take_end    = 1'b0;
        if (accept) begin
            unique case (func)
                lwm_pkg::FUNC_CLEAR: begin
                    n_len       = '0;
                    n_ovf       = 1'b0;
                    n_text_seen = 1'b0;
                    ctrl.mode   = lwm_pkg::CELL_RESTART;
                end
                lwm_pkg::FUNC_APPEND: begin
                    if (i_symbol != lwm_pkg::SYM_NUL) begin
                        if (r_len < LEN_MAX) begin
                            ctrl.append = 1'b1;
                            n_len       = r_len + LEN_W'(1);
                        end else begin
                            // store full: drop the byte, flag truncation
                            n_ovf = 1'b1;
                        end
                        n_text_seen = 1'b0;
                        ctrl.mode   = lwm_pkg::CELL_RESTART;
                    end
                end
                lwm_pkg::FUNC_TEXT: begin
                    if (i_symbol != lwm_pkg::SYM_NUL) begin
                        n_text_seen = 1'b1;
                        ctrl.mode   = lwm_pkg::CELL_ADVANCE;
                    end
                end
                lwm_pkg::FUNC_END: begin
                    take_end    = 1'b1;
                    n_text_seen = 1'b0;
                    ctrl.mode   = lwm_pkg::CELL_RESTART;
                end
                default: begin
                    ctrl.mode = lwm_pkg::CELL_HOLD;
                end
            endcase
        end
    end

    // Seed position zero on restart; nothing enters from the left otherwise.
    assign adv[0]   = (ctrl.mode == lwm_pkg::CELL_RESTART);
    assign carry[0] = 1'b0;

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
        lwm_cell #(
            .LEN_W (LEN_W),
            .IDX   (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (ctrl),
            .i_len      (r_len),
            .i_len_next (n_len),
            .i_adv      (adv[g]),
            .i_carry    (carry[g]),
            .o_adv      (adv[g+1]),
            .o_carry    (carry[g+1]),
            .o_live     (live_vec[g])
        );
    end

    // Final position past the last cell: only accepts, never advances.
    assign n_live_last = (ctrl.mode == lwm_pkg::CELL_HOLD) ? r_live_last
                                                           : (adv[MAX_PATTERN] || carry[MAX_PATTERN]);
    assign live_vec[MAX_PATTERN] = r_live_last;

    always_comb begin
        if (!r_text_seen || (r_len == '0)) begin
            result_truth = lwm_pkg::TRUTH_UNKNOWN;
        end else if (live_vec[r_len]) begin
            result_truth = lwm_pkg::TRUTH_TRUE;
        end else begin
            result_truth = lwm_pkg::TRUTH_FALSE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_text_seen <= 1'b0;
            r_live_last <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_ovf       <= n_ovf;
            r_text_seen <= n_text_seen;
            r_live_last <= n_live_last;
        end
    end

    // Result stage: output register backed by one skid entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take_end) begin
            // skid is empty here: o_stall was low
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
                r_out_truth <= result_truth;
                r_out_ovf   <= r_ovf;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid_truth <= result_truth;
                r_skid_ovf   <= r_ovf;
            end
        end else if (out_take) begin
            if (r_skid_valid) begin
                r_out_truth  <= r_skid_truth;
                r_out_ovf    <= r_skid_ovf;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stall            = r_skid_valid;
    assign o_valid            = r_out_valid;
    assign o_truth            = r_out_truth;
    assign o_pattern_overflow = r_out_ovf;

endmodule

@@ hdl/lwm_checker.sv @@
// Port-level checker for like_wildcard_matcher_core, bound to the top level.
// Depends on lwm_pkg and like_wildcard_matcher_core_macros.svh.
`timescale 1ns / 1ps
`include "like_wildcard_matcher_core_macros.svh"

module lwm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [1:0] i_func,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_truth
);

    // Hold a stalled result.
    `LWM_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, o_valid && i_stall, o_valid, "result dropped under stall")

    // Raise stall only when the output register is full too.
    `LWM_ASSERT_SAME(a_stall_needs_out, i_clk, i_rst_n, o_stall, o_valid, "stall without pending result")

    // Show an end-of-text result in the next cycle when the output is free.
    `LWM_ASSERT_NEXT(a_end_to_out, i_clk, i_rst_n, i_valid && !o_stall && (i_func == lwm_pkg::FUNC_END) && !o_valid, o_valid, "end of text produced no result")

    // Drive only defined truth codes.
    `LWM_ASSERT_SAME(a_truth_code, i_clk, i_rst_n, o_valid, (o_truth == lwm_pkg::TRUTH_FALSE) || (o_truth == lwm_pkg::TRUTH_TRUE) || (o_truth == lwm_pkg::TRUTH_UNKNOWN), "undefined truth code")

endmodule

bind like_wildcard_matcher_core lwm_checker u_lwm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_func  (i_func),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_truth (o_truth)
);

@@ tb/sv/like_wildcard_matcher_checker.sv @@
// Checker for like_wildcard_matcher_core: watches both channels, predicts each result
// from the accepted requests and compares field by field. Depends on lwm_pkg.
`timescale 1ns / 1ps

module like_wildcard_matcher_checker #(
    parameter int MAX_PATTERN = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic       i_req_stall,
    input  logic [1:0] i_func,
    input  logic [7:0] i_symbol,
    input  logic       i_res_valid,
    input  logic       i_res_stall,
    input  logic [1:0] i_truth,
    input  logic       i_pattern_overflow,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        lwm_pkg::t_truth truth;
        logic            overflow;
    } t_verdict;

    logic [7:0]         pattern_bytes [MAX_PATTERN];
    int                 pattern_len;
    logic [MAX_PATTERN:0] live_pos;
    logic               text_seen;
    logic               overflow_seen;
    t_verdict           match_verdicts [$];
    int                 fail_total = 0;

    // Propagate live positions across '%' in order, so chains of '%' close too.
    function automatic logic [MAX_PATTERN:0] close_over_wildcards(
        input logic [MAX_PATTERN:0] pos_set);
        logic [MAX_PATTERN:0] closed;
        closed = pos_set;
        for (int p = 0; p < MAX_PATTERN; p++) begin
            if (p < pattern_len && closed[p] && pattern_bytes[p] == lwm_pkg::SYM_PERCENT)
                closed[p + 1] = 1'b1;
        end
        return closed;
    endfunction

    function automatic logic [MAX_PATTERN:0] advance_positions(input logic [7:0] sym);
        logic [MAX_PATTERN:0] nxt;
        nxt = '0;
        for (int p = 0; p < MAX_PATTERN; p++) begin
            if (p < pattern_len && live_pos[p]) begin
                if (pattern_bytes[p] == lwm_pkg::SYM_PERCENT)
                    nxt[p] = 1'b1;
                else if (pattern_bytes[p] == lwm_pkg::SYM_UNDERSCORE ||
                         pattern_bytes[p] == sym)
                    nxt[p + 1] = 1'b1;
            end
        end
        return close_over_wildcards(nxt);
    endfunction

    function automatic logic [MAX_PATTERN:0] start_positions();
        logic [MAX_PATTERN:0] first;
        first    = '0;
        first[0] = 1'b1;
        return close_over_wildcards(first);
    endfunction

    always @(posedge i_clk) begin
        t_verdict        want;
        lwm_pkg::t_truth truth_now;
        if (!i_rst_n) begin
            pattern_len   = 0;
            overflow_seen = 1'b0;
            text_seen     = 1'b0;
            live_pos      = start_positions();
            match_verdicts.delete();
        end else begin
            // Compare first: a result never leaves in the cycle its request enters.
            if (i_res_valid && !i_res_stall) begin
                if (match_verdicts.size() == 0) begin
                    $error("result with no request pending: truth %0d overflow %0d",
                           i_truth, i_pattern_overflow);
                    fail_total++;
                end else begin
                    want = match_verdicts.pop_front();
                    if (i_truth !== want.truth) begin
                        $error("truth: expected %0d, actual %0d", want.truth, i_truth);
                        fail_total++;
                    end
                    if (i_pattern_overflow !== want.overflow) begin
                        $error("pattern_overflow: expected %0d, actual %0d",
                               want.overflow, i_pattern_overflow);
                        fail_total++;
                    end
                end
            end

            if (i_req_valid && !i_req_stall) begin
                case (lwm_pkg::t_func'(i_func))
                    lwm_pkg::FUNC_CLEAR: begin
                        pattern_len   = 0;
                        overflow_seen = 1'b0;
                        live_pos      = start_positions();
                        text_seen     = 1'b0;
                    end
                    lwm_pkg::FUNC_APPEND: begin
                        if (i_symbol != lwm_pkg::SYM_NUL) begin
                            if (pattern_len < MAX_PATTERN) begin
                                pattern_bytes[pattern_len] = i_symbol;
                                pattern_len++;
                            end else begin
                                overflow_seen = 1'b1;
                            end
                            live_pos  = start_positions();
                            text_seen = 1'b0;
                        end
                    end
                    lwm_pkg::FUNC_TEXT: begin
                        if (i_symbol != lwm_pkg::SYM_NUL) begin
                            live_pos  = advance_positions(i_symbol);
                            text_seen = 1'b1;
                        end
                    end
                    default: begin
                        if (!text_seen || pattern_len == 0)
                            truth_now = lwm_pkg::TRUTH_UNKNOWN;
                        else if (live_pos[pattern_len])
                            truth_now = lwm_pkg::TRUTH_TRUE;
                        else
                            truth_now = lwm_pkg::TRUTH_FALSE;
                        want.truth    = truth_now;
                        want.overflow = overflow_seen;
                        match_verdicts.push_back(want);
                        live_pos  = start_positions();
                        text_seen = 1'b0;
                    end
                endcase
            end
        end
        o_pending    <= match_verdicts.size();
        o_fail_count <= fail_total;
    end

endmodule

@@ tb/sv/tb_like_wildcard_matcher_core.sv @@
// Top of the LIKE wildcard matcher testbench: clock, reset, request stimulus and verdict.
// Depends on lwm_pkg, like_wildcard_matcher_core and like_wildcard_matcher_checker.
`timescale 1ns / 1ps

module tb_like_wildcard_matcher_core;

    localparam int MAX_PATTERN = 32;
    // Cycles with no handshake on either channel before the run is declared hung.
    localparam int HANG_LIMIT  = 2000;
    // Cycles to let pass after the last result before the verdict.
    localparam int DRAIN_CYCLES = 8;

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       i_valid  = 1'b0;
    logic [1:0] i_func   = lwm_pkg::FUNC_CLEAR;
    logic [7:0] i_symbol = 8'h00;
    logic       i_stall  = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [1:0] o_truth;
    logic       o_pattern_overflow;

    int fail_count;
    int pending_results;

    // Stimulus shaping state: idle percentages and a shadow of the loaded pattern,
    // used only to build texts that are meant to match.
    int         send_idle_pct  = 23;
    int         recv_idle_pct  = 85;
    int         accepted_items = 0;
    int         quiet_cycles   = 0;
    logic [7:0] loaded_pattern [$];

    like_wildcard_matcher_core #(
        .MAX_PATTERN(MAX_PATTERN)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_func             (i_func),
        .i_symbol           (i_symbol),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_truth            (o_truth),
        .o_pattern_overflow (o_pattern_overflow)
    );

    like_wildcard_matcher_checker #(
        .MAX_PATTERN(MAX_PATTERN)
    ) checker_inst (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req_valid        (i_valid),
        .i_req_stall        (o_stall),
        .i_func             (i_func),
        .i_symbol           (i_symbol),
        .i_res_valid        (o_valid),
        .i_res_stall        (i_stall),
        .i_truth            (o_truth),
        .i_pattern_overflow (o_pattern_overflow),
        .o_fail_count       (fail_count),
        .o_pending          (pending_results)
    );

    // 4 ns clock, first rising edge at 2 ns.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver back-pressure: stall at random at the current rate.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Hang detection: count cycles in which neither channel moves anything.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one request, with random idle cycles ahead of it, and hold it until taken.
    // Valid stays high on return so back-to-back requests need no second assignment.
    task automatic send_request(input lwm_pkg::t_func fn, input logic [7:0] sym);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_func   <= fn;
        i_symbol <= sym;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);

        case (fn)
            lwm_pkg::FUNC_CLEAR:  loaded_pattern.delete();
            lwm_pkg::FUNC_APPEND: begin
                if (sym != lwm_pkg::SYM_NUL && loaded_pattern.size() < MAX_PATTERN)
                    loaded_pattern.push_back(sym);
            end
            default: ;
        endcase
        // Zero bytes on append or text leave the block untouched; do not count them.
        if (!((fn == lwm_pkg::FUNC_APPEND || fn == lwm_pkg::FUNC_TEXT) &&
              sym == lwm_pkg::SYM_NUL))
            accepted_items++;
    endtask

    // Drop valid and hold off until every pending result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pattern_symbol();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30) return lwm_pkg::SYM_PERCENT;
        if (pick < 50) return lwm_pkg::SYM_UNDERSCORE;
        if (pick < 90) return 8'h61 + 8'($urandom_range(2));
        if (pick < 95) return lwm_pkg::SYM_NUL;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] text_symbol();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) return 8'h61 + 8'($urandom_range(2));
        if (pick < 75) return lwm_pkg::SYM_PERCENT;
        if (pick < 80) return lwm_pkg::SYM_UNDERSCORE;
        if (pick < 85) return lwm_pkg::SYM_NUL;
        return 8'($urandom_range(1, 255));
    endfunction

    // Build a text that fits the loaded pattern: '%' takes zero to two letters,
    // '_' any nonzero byte, every other byte itself.
    task automatic send_matching_text();
        int         plen;
        logic [7:0] pb;
        plen = loaded_pattern.size();
        for (int i = 0; i < plen; i++) begin
            pb = loaded_pattern[i];
            if (pb == lwm_pkg::SYM_PERCENT)
                repeat ($urandom_range(2))
                    send_request(lwm_pkg::FUNC_TEXT, 8'h61 + 8'($urandom_range(2)));
            else if (pb == lwm_pkg::SYM_UNDERSCORE)
                send_request(lwm_pkg::FUNC_TEXT, 8'($urandom_range(1, 255)));
            else
                send_request(lwm_pkg::FUNC_TEXT, pb);
        end
    endtask

    // One well-formed job: usually a fresh pattern, then one to three texts each
    // closed by END. Some patterns run past the store to exercise truncation.
    task automatic run_sequence();
        int plen;
        int n_texts;
        int tlen;
        if ($urandom_range(3) != 0) begin
            send_request(lwm_pkg::FUNC_CLEAR, 8'($urandom_range(255)));
            plen = ($urandom_range(9) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 6);
            repeat (plen) send_request(lwm_pkg::FUNC_APPEND, pattern_symbol());
        end
        n_texts = $urandom_range(1, 3);
        repeat (n_texts) begin
            if ($urandom_range(1)) begin
                send_matching_text();
            end else begin
                tlen = $urandom_range(8);
                repeat (tlen) send_request(lwm_pkg::FUNC_TEXT, text_symbol());
            end
            send_request(lwm_pkg::FUNC_END, 8'($urandom_range(255)));
        end
    endtask

    // Mostly well-formed jobs, the rest raw requests of any kind in any order.
    task automatic run_phase(input int send_pct, input int recv_pct, input int n_items);
        int target;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target = accepted_items + n_items;
        while (accepted_items < target) begin
            if ($urandom_range(99) < 80)
                run_sequence();
            else
                repeat ($urandom_range(1, 4))
                    send_request(lwm_pkg::t_func'($urandom_range(3)),
                                 8'($urandom_range(255)));
        end
        drain_results();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty pattern and empty text give unknown.
        send_request(lwm_pkg::FUNC_END, 8'h00);
        send_request(lwm_pkg::FUNC_TEXT, 8'h78);
        send_request(lwm_pkg::FUNC_END, 8'hFF);
        // Zero pattern byte is dropped; load "a%b".
        send_request(lwm_pkg::FUNC_APPEND, lwm_pkg::SYM_NUL);
        send_request(lwm_pkg::FUNC_APPEND, 8'h61);
        send_request(lwm_pkg::FUNC_APPEND, lwm_pkg::SYM_PERCENT);
        send_request(lwm_pkg::FUNC_APPEND, 8'h62);
        // Pattern but no text: unknown.
        send_request(lwm_pkg::FUNC_END, 8'h00);
        // "a<nul>zb" matches, the zero text byte is dropped.
        send_request(lwm_pkg::FUNC_TEXT, 8'h61);
        send_request(lwm_pkg::FUNC_TEXT, lwm_pkg::SYM_NUL);
        send_request(lwm_pkg::FUNC_TEXT, 8'h7A);
        send_request(lwm_pkg::FUNC_TEXT, 8'h62);
        send_request(lwm_pkg::FUNC_END, 8'h00);
        // Case sensitive: "Ab" does not match.
        send_request(lwm_pkg::FUNC_TEXT, 8'h41);
        send_request(lwm_pkg::FUNC_TEXT, 8'h62);
        send_request(lwm_pkg::FUNC_END, 8'h00);
        // Pattern "_<ff>" against extreme bytes.
        send_request(lwm_pkg::FUNC_CLEAR, 8'hFF);
        send_request(lwm_pkg::FUNC_APPEND, lwm_pkg::SYM_UNDERSCORE);
        send_request(lwm_pkg::FUNC_APPEND, 8'hFF);
        send_request(lwm_pkg::FUNC_TEXT, 8'h01);
        send_request(lwm_pkg::FUNC_TEXT, 8'hFF);
        send_request(lwm_pkg::FUNC_END, 8'h00);
        // One byte too many for '_' then literal.
        send_request(lwm_pkg::FUNC_TEXT, lwm_pkg::SYM_PERCENT);
        send_request(lwm_pkg::FUNC_TEXT, 8'h01);
        send_request(lwm_pkg::FUNC_TEXT, 8'hFF);
        send_request(lwm_pkg::FUNC_END, 8'h00);

        // Three idle profiles; each phase ends by waiting for all results.
        run_phase(23, 85, 275);
        run_phase(85, 23, 275);
        run_phase(0, 0, 275);

        // Let any stray late result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
